// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the step counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define SHC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: cond");

// Consequent must hold in the same cycle as the antecedent.
`define SHC_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Consequent must hold in the cycle after the antecedent.
`define SHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

// ===== rtl/shc_pkg.sv =====
// Package: widths, constants, codes and types of the step counter.
package shc_pkg;

    localparam int FIELD_W    = 14;
    localparam int SQ_W       = 27;
    localparam int SUMSQ_W    = 28;
    localparam int SQRT_STEPS = 14;
    localparam int ITER_W     = 4;
    localparam int TOTAL_W    = 32;

    localparam int WINDOW_LEN = 5;
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WSUM_W     = $clog2(WINDOW_LEN * 16383 + 1);
    localparam int DIV_K      = WSUM_W + POS_W + 1;
    localparam int PROD_W     = WSUM_W + DIV_K + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << DIV_K) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [DIV_K:0] DIV_RECIP = (DIV_K + 1)'(RECIP_L);

    localparam logic [FIELD_W-1:0] ONE_G         = 14'd256;
    localparam logic [FIELD_W-1:0] ARM_RESET     = 14'd307;
    localparam logic [FIELD_W-1:0] RELEASE_RESET = 14'd230;
    localparam logic [WSUM_W-1:0]  WSUM_RESET    = WSUM_W'(WINDOW_LEN * 256);
    localparam logic [SUMSQ_W-1:0] ROOT_BIT_TOP  = SUMSQ_W'(1) << (2 * SQRT_STEPS - 2);

    localparam int CFG_IDX_W  = 8;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_ARM     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 8'd1;

    typedef struct packed {
        logic               valid;
        logic [SUMSQ_W-1:0] data;
    } shc_item_t;

endpackage

// ===== rtl/shc_queue.sv =====
// Two-entry queue of sums of squares between the front and back parts.
module shc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  shc_pkg::shc_item_t push_item,
    output logic              push_ready,
    output shc_pkg::shc_item_t pop_item,
    input  logic              pop_ready
);
    import shc_pkg::*;

    logic [SUMSQ_W-1:0] entry_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready     = (cnt_reg != 2'd2);
    assign pop_item.valid = (cnt_reg != 2'd0);
    assign pop_item.data  = entry_reg[rd_ptr_reg];
    assign do_push        = push_item.valid && push_ready;
    assign do_pop         = pop_item.valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item.data;
        end
    end

`include "assert_macros.svh"
    `SHC_ASSERT_ALWAYS(a_q_count_range, cnt_reg != 2'd3)
    `SHC_ASSERT_IMPLIES(a_q_ptr_match, cnt_reg == 2'd0 || cnt_reg == 2'd2,
                        wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/shc_front.sv =====
// Front part: accept samples, square the axes and sum the squares.
module shc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [shc_pkg::IN_DATA_W-1:0] s_tdata,
    output shc_pkg::shc_item_t           push_item,
    input  logic                         push_ready
);
    import shc_pkg::*;

    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [SUMSQ_W-1:0] sqx_full;
    logic signed [SUMSQ_W-1:0] sqy_full;
    logic signed [SUMSQ_W-1:0] sqz_full;
    logic [SQ_W-1:0]           sqx_reg;
    logic [SQ_W-1:0]           sqy_reg;
    logic [SQ_W-1:0]           sqz_reg;
    logic                      v1_reg;
    logic                      take;
    logic                      push;

    assign ax = s_tdata[FIELD_W-1:0];
    assign ay = s_tdata[2*FIELD_W-1:FIELD_W];
    assign az = s_tdata[3*FIELD_W-1:2*FIELD_W];

    assign sqx_full = ax * ax;
    assign sqy_full = ay * ay;
    assign sqz_full = az * az;

    assign push     = v1_reg && push_ready;
    assign s_tready = !v1_reg || push_ready;
    assign take     = s_tvalid && s_tready;

    assign push_item.valid = v1_reg;
    assign push_item.data  = SUMSQ_W'(sqx_reg) + SUMSQ_W'(sqy_reg) + SUMSQ_W'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (take)
        begin
            v1_reg <= 1'b1;
        end
        else if (push)
        begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sqx_reg <= sqx_full[SQ_W-1:0];
            sqy_reg <= sqy_full[SQ_W-1:0];
            sqz_reg <= sqz_full[SQ_W-1:0];
        end
    end

`include "assert_macros.svh"
    `SHC_ASSERT_NEXT(a_front_hold, v1_reg && !push_ready, v1_reg)

endmodule

// ===== rtl/shc_back.sv =====
// Back part: square root, window mean, hysteresis, step count and result register.
module shc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shc_pkg::shc_item_t            pop_item,
    output logic                          pop_ready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [shc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shc_pkg::FIELD_W-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [shc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import shc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIX  = 5'b10000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SUMSQ_W-1:0]  rem_reg;
    logic [SUMSQ_W-1:0]  res_reg;
    logic [SUMSQ_W-1:0]  bit_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic [FIELD_W-1:0]  win_reg [WINDOW_LEN];
    logic [POS_W-1:0]    pos_reg;
    logic [WSUM_W-1:0]   wsum_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                armed_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [FIELD_W-1:0]  arm_thr_reg;
    logic [FIELD_W-1:0]  rel_thr_reg;
    logic                out_valid_reg;
    logic                out_seen_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [FIELD_W-1:0]  out_mean_reg;

    logic [SUMSQ_W-1:0]  trial;
    logic                fits;
    logic [FIELD_W-1:0]  mag;
    logic [FIELD_W-1:0]  old_mag;
    logic [FIELD_W-1:0]  mean;
    logic                armed_mid;
    logic                seen;
    logic                out_free;
    logic                out_load;

    assign pop_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign trial    = res_reg + bit_reg;
    assign fits     = (rem_reg >= trial);
    assign mag      = res_reg[FIELD_W-1:0];
    assign old_mag  = win_reg[pos_reg];
    assign mean     = prod_reg[DIV_K +: FIELD_W];
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_FIX) && out_free;

    // Arm test first, then release test on the updated flag.
    assign armed_mid = armed_reg || (mean > arm_thr_reg);
    assign seen      = armed_mid && (mean < rel_thr_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_item.valid)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (iter_reg == ITER_W'(0))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            wsum_reg      <= WSUM_RESET;
            armed_reg     <= 1'b0;
            total_reg     <= '0;
            arm_thr_reg   <= ARM_RESET;
            rel_thr_reg   <= RELEASE_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= ONE_G;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == REG_ARM)
                begin
                    arm_thr_reg <= cfg_data;
                end
                else if (cfg_index == REG_RELEASE)
                begin
                    rel_thr_reg <= cfg_data;
                end
            end
            if (state_reg == ST_UPD)
            begin
                win_reg[pos_reg] <= mag;
                wsum_reg <= wsum_reg - WSUM_W'(old_mag) + WSUM_W'(mag);
                if (pos_reg == POS_W'(WINDOW_LEN - 1))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            if (out_load)
            begin
                armed_reg <= armed_mid && !seen;
                if (seen)
                begin
                    total_reg <= total_reg + TOTAL_W'(1);
                end
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Square root datapath (one result bit per cycle), reciprocal multiply and result capture.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            rem_reg  <= pop_item.data;
            res_reg  <= '0;
            bit_reg  <= ROOT_BIT_TOP;
            iter_reg <= ITER_W'(SQRT_STEPS - 1);
        end
        else if (state_reg == ST_SQRT)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            iter_reg <= iter_reg - ITER_W'(1);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(wsum_reg) * PROD_W'(DIV_RECIP);
        end
        if (out_load)
        begin
            out_seen_reg  <= seen;
            out_total_reg <= seen ? total_reg + TOTAL_W'(1) : total_reg;
            out_mean_reg  <= mean;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mean_reg, out_total_reg, out_seen_reg};

`include "assert_macros.svh"
    `SHC_ASSERT_NEXT(a_total_step, out_load && seen, total_reg == $past(total_reg) + 32'd1)
    `SHC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready && state_reg != ST_FIX,
                     m_tvalid && $stable(m_tdata))

endmodule

// ===== rtl/step_counter_hysteresis_top.sv =====
// Top level of the pedometer step counter with hysteresis.
// Usage:
//   Input stream s_*: one three-axis acceleration sample per transaction,
//   256 per g, two's complement. Output stream m_*: exactly one result per
//   sample, in order: step flag, running step total, window mean magnitude.
//   Config channel cfg_*: index 0 writes arm_threshold, 1 release_threshold;
//   other indexes are dropped. cfg_ready is always high; write while idle.
// Flow:
//   The front registers the squares of the axes and hands their sum to a
//   two-entry queue. The back takes one sample at a time and accepts no new
//   sample until its result is loaded: bit-serial square root, then window
//   update, reciprocal multiply and decision.
// Reset:
//   rst_n clears all control state; the window holds 1 g in every entry,
//   thresholds return to 307 and 230, the step total to zero.
// Backpressure:
//   A stalled m_tready holds the result register; the back waits, the queue
//   fills, and then s_tready drops.
module step_counter_hysteresis_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: [13:0] accel_x, [27:14] accel_y, [41:28] accel_z, [47:42] zero
    input  logic [shc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: [0] step_seen, [32:1] steps_total, [46:33] smoothed_magnitude, [47] zero
    output logic [shc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [shc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shc_pkg::FIELD_W-1:0]    cfg_data
);
    import shc_pkg::*;

    shc_item_t push_item;
    logic      push_ready;
    shc_item_t pop_item;
    logic      pop_ready;

    shc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    shc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    shc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
